@@ design/ttf_pkg.sv @@
// ttf_pkg: types, widths and codes shared by the triangle tangent frame block
// used by ttf_ctrl, ttf_datapath and triangle_tangent_frame; no dependencies
package ttf_pkg;

    localparam int CW        = 16;
    localparam int NW        = 16;
    localparam int DW        = 17;
    localparam int DELTA_SHR = (CW > 16) ? CW - 16 : 0;
    localparam int NRM_SHR   = (CW > 16) ? CW - 16 : 0;
    localparam int NRM_SHL   = (CW < 16) ? 16 - CW : 0;

    localparam int TBW    = 2 * DW + 2;
    localparam int TB_FIT = 20;
    localparam int TFW    = TB_FIT + 1;
    localparam int CRW    = NW + TFW + 1;
    localparam int DOTW   = NW + TFW + 2;
    localparam int VW     = 56;
    localparam int V_FIT  = 30;
    localparam int VFW    = V_FIT + 1;
    localparam int T_SHL  = 28;

    localparam int AW    = 40;
    localparam int BW    = 32;
    localparam int ACCW  = 64;
    localparam int SQW   = 64;
    localparam int RW    = SQW;
    localparam int QW    = CW - 1;
    localparam int NUMW  = VFW + CW - 1;
    localparam int REMW  = 32;

    localparam logic [1:0] CORNER_LAST = 2'd2;
    localparam logic [1:0] AXIS_LAST   = 2'd2;

    localparam logic [4:0] DET_LAST   = 5'd1;
    localparam logic [4:0] TB_LAST    = 5'd11;
    localparam logic [4:0] CROSS_LAST = 5'd5;
    localparam logic [4:0] SUM3_LAST  = 5'd2;
    localparam logic [4:0] SQRT_LAST  = 5'd31;
    localparam logic [4:0] DIV_LAST   = 5'(QW);

    typedef struct packed {
        logic [1:0]             corner;
        logic signed [CW-1:0]   pos_x;
        logic signed [CW-1:0]   pos_y;
        logic signed [CW-1:0]   pos_z;
        logic signed [CW-1:0]   tex_u;
        logic signed [CW-1:0]   tex_v;
        logic signed [CW-1:0]   norm_x;
        logic signed [CW-1:0]   norm_y;
        logic signed [CW-1:0]   norm_z;
    } vertex_t;

    typedef struct packed {
        logic signed [CW-1:0]   tangent_x;
        logic signed [CW-1:0]   tangent_y;
        logic signed [CW-1:0]   tangent_z;
        logic                   handedness;
        logic                   degenerate;
        logic                   last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET,
        ST_TB,
        ST_FIT_TB,
        ST_CROSS,
        ST_HAND,
        ST_DOT,
        ST_VEC,
        ST_FIT_V,
        ST_LEN2,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DET,
        OP_TB,
        OP_FIT_TB,
        OP_CROSS,
        OP_HAND,
        OP_DOT,
        OP_VEC,
        OP_FIT_V,
        OP_LEN2,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] step;
        logic [1:0] corner;
        logic [1:0] comp;
        logic       zero;
    } cmd_t;

    typedef struct packed {
        logic det_zero;
        logic tb_fit;
        logic v_fit;
        logic len_zero;
        logic out_free;
    } status_t;

    function automatic logic [1:0] next_axis(input logic [1:0] j);
        logic [1:0] r;
        case (j)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/triangle_tangent_frame.sv @@
// Per-triangle tangent frame. Vertices arrive as corners 0, 1, 2; corners 0 and 1
// are stored. Corner 2 starts the triangle computation on one shared
// multiply-accumulate unit, a one-bit-per-step square root and a one-bit-per-step
// divider: first the determinant and face tangent (and their scaling), then for
// each corner the scaling, the square root and the three divisions, which a zero
// length skips. No vertex is accepted until the triangle is done. A zero UV
// determinant goes straight to the three results. Results leave through an output
// register; a stalled result holds the datapath at that corner.
// depends on ttf_pkg, ttf_ctrl, ttf_datapath
module triangle_tangent_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  ttf_pkg::vertex_t  vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output ttf_pkg::result_t  result
);

    ttf_pkg::cmd_t    cmd;
    ttf_pkg::status_t status;

    ttf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .vertex_valid  (vertex_valid),
        .vertex_corner (vertex.corner),
        .vertex_stall  (vertex_stall),
        .status        (status),
        .cmd           (cmd)
    );

    ttf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ design/ttf_ctrl.sv @@
// ttf_ctrl: sequencer for the tangent frame datapath
// depends on ttf_pkg
module ttf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    input  logic [1:0]        vertex_corner,
    output logic              vertex_stall,
    input  ttf_pkg::status_t  status,
    output ttf_pkg::cmd_t     cmd
);

    ttf_pkg::state_t state_reg, state_next;
    logic [4:0]      step_reg, step_next;
    logic [1:0]      corner_reg, corner_next;
    logic [1:0]      comp_reg, comp_next;
    logic            zero_reg, zero_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ttf_pkg::ST_IDLE;
            step_reg   <= '0;
            corner_reg <= '0;
            comp_reg   <= '0;
            zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
            comp_reg   <= comp_next;
            zero_reg   <= zero_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg + 5'd1;
        corner_next = corner_reg;
        comp_next   = comp_reg;
        zero_next   = zero_reg;
        case (state_reg)
            ttf_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (vertex_valid && vertex_corner == ttf_pkg::CORNER_LAST)
                    state_next = ttf_pkg::ST_DET;
            end
            ttf_pkg::ST_DET:
            begin
                if (step_reg == ttf_pkg::DET_LAST)
                begin
                    state_next = ttf_pkg::ST_TB;
                    step_next  = '0;
                end
            end
            ttf_pkg::ST_TB:
            begin
                if (step_reg == '0 && status.det_zero)
                begin
                    state_next  = ttf_pkg::ST_EMIT;
                    zero_next   = 1'b1;
                    corner_next = '0;
                end
                else if (step_reg == ttf_pkg::TB_LAST)
                    state_next = ttf_pkg::ST_FIT_TB;
            end
            ttf_pkg::ST_FIT_TB:
            begin
                if (status.tb_fit)
                begin
                    state_next  = ttf_pkg::ST_CROSS;
                    step_next   = '0;
                    corner_next = '0;
                end
            end
            ttf_pkg::ST_CROSS:
            begin
                if (step_reg == ttf_pkg::CROSS_LAST)
                begin
                    state_next = ttf_pkg::ST_HAND;
                    step_next  = '0;
                end
            end
            ttf_pkg::ST_HAND:
            begin
                if (step_reg == ttf_pkg::SUM3_LAST)
                begin
                    state_next = ttf_pkg::ST_DOT;
                    step_next  = '0;
                end
            end
            ttf_pkg::ST_DOT:
            begin
                if (step_reg == ttf_pkg::SUM3_LAST)
                begin
                    state_next = ttf_pkg::ST_VEC;
                    step_next  = '0;
                end
            end
            ttf_pkg::ST_VEC:
            begin
                if (step_reg == ttf_pkg::SUM3_LAST)
                    state_next = ttf_pkg::ST_FIT_V;
            end
            ttf_pkg::ST_FIT_V:
            begin
                step_next = '0;
                if (status.v_fit)
                    state_next = ttf_pkg::ST_LEN2;
            end
            ttf_pkg::ST_LEN2:
            begin
                if (step_reg == ttf_pkg::SUM3_LAST)
                begin
                    state_next = ttf_pkg::ST_SQRT;
                    step_next  = '0;
                end
            end
            ttf_pkg::ST_SQRT:
            begin
                if (step_reg == ttf_pkg::SQRT_LAST)
                begin
                    state_next = ttf_pkg::ST_DIV;
                    step_next  = '0;
                    comp_next  = '0;
                end
            end
            ttf_pkg::ST_DIV:
            begin
                if (step_reg == '0 && status.len_zero)
                    state_next = ttf_pkg::ST_EMIT;
                else if (step_reg == ttf_pkg::DIV_LAST)
                begin
                    step_next = '0;
                    if (comp_reg == ttf_pkg::AXIS_LAST)
                        state_next = ttf_pkg::ST_EMIT;
                    else
                        comp_next = comp_reg + 2'd1;
                end
            end
            ttf_pkg::ST_EMIT:
            begin
                step_next = '0;
                if (status.out_free)
                begin
                    if (corner_reg == ttf_pkg::CORNER_LAST)
                    begin
                        state_next = ttf_pkg::ST_IDLE;
                        zero_next  = 1'b0;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        if (!zero_reg)
                            state_next = ttf_pkg::ST_CROSS;
                    end
                end
            end
            default:
            begin
                state_next = ttf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        vertex_stall = (state_reg != ttf_pkg::ST_IDLE);
        cmd.step     = step_reg;
        cmd.corner   = corner_reg;
        cmd.comp     = comp_reg;
        cmd.zero     = zero_reg;
        case (state_reg)
            ttf_pkg::ST_IDLE:   cmd.op = vertex_valid ? ttf_pkg::OP_LOAD : ttf_pkg::OP_NONE;
            ttf_pkg::ST_DET:    cmd.op = ttf_pkg::OP_DET;
            ttf_pkg::ST_TB:
                cmd.op = (step_reg == '0 && status.det_zero) ? ttf_pkg::OP_NONE
                                                             : ttf_pkg::OP_TB;
            ttf_pkg::ST_FIT_TB: cmd.op = ttf_pkg::OP_FIT_TB;
            ttf_pkg::ST_CROSS:  cmd.op = ttf_pkg::OP_CROSS;
            ttf_pkg::ST_HAND:   cmd.op = ttf_pkg::OP_HAND;
            ttf_pkg::ST_DOT:    cmd.op = ttf_pkg::OP_DOT;
            ttf_pkg::ST_VEC:    cmd.op = ttf_pkg::OP_VEC;
            ttf_pkg::ST_FIT_V:  cmd.op = ttf_pkg::OP_FIT_V;
            ttf_pkg::ST_LEN2:   cmd.op = ttf_pkg::OP_LEN2;
            ttf_pkg::ST_SQRT:   cmd.op = ttf_pkg::OP_SQRT;
            ttf_pkg::ST_DIV:
            begin
                if (step_reg == '0)
                    cmd.op = status.len_zero ? ttf_pkg::OP_NONE : ttf_pkg::OP_DIV_INIT;
                else
                    cmd.op = ttf_pkg::OP_DIV;
            end
            ttf_pkg::ST_EMIT:   cmd.op = status.out_free ? ttf_pkg::OP_EMIT : ttf_pkg::OP_NONE;
            default:            cmd.op = ttf_pkg::OP_NONE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttf_pkg::ST_EMIT && status.out_free
         && corner_reg == ttf_pkg::CORNER_LAST) |=> state_reg == ttf_pkg::ST_IDLE)
        else $error("triangle did not end after its third result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttf_pkg::ST_SQRT && step_reg == ttf_pkg::SQRT_LAST)
        |=> (state_reg == ttf_pkg::ST_DIV && step_reg == '0 && comp_reg == '0))
        else $error("divide did not start from the first component");

endmodule

@@ design/ttf_datapath.sv @@
// ttf_datapath: corner store, shared multiply-accumulate, square root and divider,
// result register; depends on ttf_pkg
module ttf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ttf_pkg::cmd_t     cmd,
    output ttf_pkg::status_t  status,
    input  ttf_pkg::vertex_t  vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output ttf_pkg::result_t  result
);

    localparam logic [ttf_pkg::TBW-1:0] TB_LIM = ttf_pkg::TBW'(1) << ttf_pkg::TB_FIT;
    localparam logic [ttf_pkg::VW-1:0]  V_LIM  = ttf_pkg::VW'(1) << ttf_pkg::V_FIT;
    localparam logic [ttf_pkg::SQW-1:0] SQ_TOP = ttf_pkg::SQW'(1) << (ttf_pkg::SQW - 2);

    logic signed [ttf_pkg::CW-1:0]   pos_reg [2][3];
    logic signed [ttf_pkg::CW-1:0]   uv_reg  [2][2];
    logic signed [ttf_pkg::NW-1:0]   nrm_reg [2][3];
    logic signed [ttf_pkg::NW-1:0]   cur_nrm_reg [3];
    logic signed [ttf_pkg::DW-1:0]   e1_reg [3];
    logic signed [ttf_pkg::DW-1:0]   e2_reg [3];
    logic signed [ttf_pkg::DW-1:0]   x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [ttf_pkg::ACCW-1:0] acc_reg;
    logic                            det_neg_reg, det_zero_reg;
    logic signed [ttf_pkg::TBW-1:0]  tb_reg [6];
    logic [ttf_pkg::TBW-1:0]         m_tb_reg;
    logic signed [ttf_pkg::CRW-1:0]  c_reg [3];
    logic                            hand_reg;
    logic signed [ttf_pkg::DOTW-1:0] dot_reg;
    logic signed [ttf_pkg::VW-1:0]   v_reg [3];
    logic [ttf_pkg::VW-1:0]          m_v_reg;
    logic [ttf_pkg::SQW-1:0]         sq_x_reg, sq_bit_reg;
    logic [ttf_pkg::RW-1:0]          sq_r_reg;
    logic [ttf_pkg::REMW-1:0]        rem_reg;
    logic [ttf_pkg::QW-1:0]          numlo_reg, q_reg;
    logic signed [ttf_pkg::CW-1:0]   tan_reg [3];
    logic                            out_valid_reg;
    ttf_pkg::result_t                result_reg;

    logic signed [ttf_pkg::NW-1:0]   n_sel [3];
    logic signed [ttf_pkg::NW-1:0]   n_in [3];
    logic signed [ttf_pkg::CW-1:0]   p_in [3];
    logic signed [ttf_pkg::TFW-1:0]  t_f [3];
    logic signed [ttf_pkg::TFW-1:0]  b_f [3];
    logic signed [ttf_pkg::VFW-1:0]  v_f [3];
    logic signed [ttf_pkg::AW-1:0]   a_op;
    logic signed [ttf_pkg::BW-1:0]   b_op;
    logic signed [ttf_pkg::AW+ttf_pkg::BW-1:0] prod_full;
    logic signed [ttf_pkg::ACCW-1:0] prod, acc_add, acc_sub;
    logic [2:0]                      tb_d;
    logic [1:0]                      tb_i, ax_j, ax_j1, ax_j2, s2;
    logic signed [ttf_pkg::TBW-1:0]  tb_raw, tb_val;
    logic [ttf_pkg::TBW-1:0]         tb_mag;
    logic signed [ttf_pkg::VW-1:0]   vec_val;
    logic [ttf_pkg::VW-1:0]          vec_mag;
    logic [ttf_pkg::SQW-1:0]         sq_sum;
    logic                            sq_ge;
    logic [ttf_pkg::VFW-1:0]         div_mag;
    logic [ttf_pkg::NUMW-1:0]        div_num;
    logic [ttf_pkg::REMW-1:0]        rem_sh;
    logic                            div_ge;
    logic [ttf_pkg::QW-1:0]          q_next;
    logic signed [ttf_pkg::CW-1:0]   tan_val;
    logic                            out_free;

    function automatic logic signed [ttf_pkg::DW-1:0] delta(
        input logic signed [ttf_pkg::CW-1:0] a,
        input logic signed [ttf_pkg::CW-1:0] b
    );
        logic signed [ttf_pkg::CW:0] d;
        d = {a[ttf_pkg::CW-1], a} - {b[ttf_pkg::CW-1], b};
        return ttf_pkg::DW'(d >>> ttf_pkg::DELTA_SHR);
    endfunction

    function automatic logic signed [ttf_pkg::NW-1:0] to_q14(
        input logic signed [ttf_pkg::CW-1:0] x
    );
        logic signed [31:0] ext;
        ext = 32'(x);
        return ttf_pkg::NW'((ext >>> ttf_pkg::NRM_SHR) <<< ttf_pkg::NRM_SHL);
    endfunction

    always_comb
    begin
        p_in[0] = vertex.pos_x;
        p_in[1] = vertex.pos_y;
        p_in[2] = vertex.pos_z;
        n_in[0] = to_q14(vertex.norm_x);
        n_in[1] = to_q14(vertex.norm_y);
        n_in[2] = to_q14(vertex.norm_z);
        for (int k = 0; k < 3; k++)
        begin
            n_sel[k] = (cmd.corner == ttf_pkg::CORNER_LAST) ? cur_nrm_reg[k]
                                                            : nrm_reg[cmd.corner[0]][k];
            t_f[k]   = ttf_pkg::TFW'(tb_reg[k]);
            b_f[k]   = ttf_pkg::TFW'(tb_reg[k+3]);
            v_f[k]   = ttf_pkg::VFW'(v_reg[k]);
        end
    end

    // operand selection for the shared multiply-accumulate
    always_comb
    begin
        tb_d  = cmd.step[3:1];
        tb_i  = (tb_d < 3'd3) ? tb_d[1:0] : 2'(tb_d - 3'd3);
        ax_j  = cmd.step[2:1];
        ax_j1 = ttf_pkg::next_axis(ax_j);
        ax_j2 = ttf_pkg::next_axis(ax_j1);
        s2    = cmd.step[1:0];
        a_op  = '0;
        b_op  = '0;
        case (cmd.op)
            ttf_pkg::OP_DET:
            begin
                a_op = cmd.step[0] ? ttf_pkg::AW'(x2_reg) : ttf_pkg::AW'(x1_reg);
                b_op = cmd.step[0] ? ttf_pkg::BW'(y1_reg) : ttf_pkg::BW'(y2_reg);
            end
            ttf_pkg::OP_TB:
            begin
                if (tb_d < 3'd3)
                begin
                    a_op = cmd.step[0] ? ttf_pkg::AW'(e2_reg[tb_i]) : ttf_pkg::AW'(e1_reg[tb_i]);
                    b_op = cmd.step[0] ? ttf_pkg::BW'(y1_reg) : ttf_pkg::BW'(y2_reg);
                end
                else
                begin
                    a_op = cmd.step[0] ? ttf_pkg::AW'(e1_reg[tb_i]) : ttf_pkg::AW'(e2_reg[tb_i]);
                    b_op = cmd.step[0] ? ttf_pkg::BW'(x2_reg) : ttf_pkg::BW'(x1_reg);
                end
            end
            ttf_pkg::OP_CROSS:
            begin
                a_op = cmd.step[0] ? ttf_pkg::AW'(t_f[ax_j1]) : ttf_pkg::AW'(t_f[ax_j2]);
                b_op = cmd.step[0] ? ttf_pkg::BW'(n_sel[ax_j2]) : ttf_pkg::BW'(n_sel[ax_j1]);
            end
            ttf_pkg::OP_HAND:
            begin
                a_op = ttf_pkg::AW'(c_reg[s2]);
                b_op = ttf_pkg::BW'(b_f[s2]);
            end
            ttf_pkg::OP_DOT:
            begin
                a_op = ttf_pkg::AW'(t_f[s2]);
                b_op = ttf_pkg::BW'(n_sel[s2]);
            end
            ttf_pkg::OP_VEC:
            begin
                a_op = ttf_pkg::AW'(dot_reg);
                b_op = ttf_pkg::BW'(n_sel[s2]);
            end
            ttf_pkg::OP_LEN2:
            begin
                a_op = ttf_pkg::AW'(v_f[s2]);
                b_op = ttf_pkg::BW'(v_f[s2]);
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    always_comb
    begin
        prod_full = a_op * b_op;
        prod      = ttf_pkg::ACCW'(prod_full);
        acc_add   = acc_reg + prod;
        acc_sub   = acc_reg - prod;

        tb_raw = ttf_pkg::TBW'(acc_sub);
        tb_val = det_neg_reg ? -tb_raw : tb_raw;
        tb_mag = tb_val[ttf_pkg::TBW-1] ? ttf_pkg::TBW'(-tb_val) : ttf_pkg::TBW'(tb_val);

        vec_val = (ttf_pkg::VW'(t_f[s2]) <<< ttf_pkg::T_SHL) - ttf_pkg::VW'(prod);
        vec_mag = vec_val[ttf_pkg::VW-1] ? ttf_pkg::VW'(-vec_val) : ttf_pkg::VW'(vec_val);

        sq_sum = ttf_pkg::SQW'(sq_r_reg) + sq_bit_reg;
        sq_ge  = (sq_x_reg >= sq_sum);

        div_mag = v_f[cmd.comp][ttf_pkg::VFW-1] ? ttf_pkg::VFW'(-v_f[cmd.comp])
                                                : ttf_pkg::VFW'(v_f[cmd.comp]);
        div_num = (ttf_pkg::NUMW'(div_mag) << (ttf_pkg::CW - 2))
                  + ttf_pkg::NUMW'(sq_r_reg >> 1);
        rem_sh  = {rem_reg[ttf_pkg::REMW-2:0], numlo_reg[ttf_pkg::QW-1]};
        div_ge  = (rem_sh >= ttf_pkg::REMW'(sq_r_reg));
        q_next  = {q_reg[ttf_pkg::QW-2:0], div_ge};
        tan_val = v_f[cmd.comp][ttf_pkg::VFW-1] ? -ttf_pkg::CW'({1'b0, q_next})
                                                : ttf_pkg::CW'({1'b0, q_next});
        out_free = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ttf_pkg::OP_LOAD:
            begin
                if (vertex.corner == ttf_pkg::CORNER_LAST)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        e1_reg[k]      <= delta(pos_reg[1][k], pos_reg[0][k]);
                        e2_reg[k]      <= delta(p_in[k], pos_reg[0][k]);
                        cur_nrm_reg[k] <= n_in[k];
                    end
                    x1_reg <= delta(uv_reg[1][0], uv_reg[0][0]);
                    x2_reg <= delta(vertex.tex_u, uv_reg[0][0]);
                    y1_reg <= delta(uv_reg[1][1], uv_reg[0][1]);
                    y2_reg <= delta(vertex.tex_v, uv_reg[0][1]);
                end
                else if (vertex.corner < ttf_pkg::CORNER_LAST)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pos_reg[vertex.corner[0]][k] <= p_in[k];
                        nrm_reg[vertex.corner[0]][k] <= n_in[k];
                    end
                    uv_reg[vertex.corner[0]][0] <= vertex.tex_u;
                    uv_reg[vertex.corner[0]][1] <= vertex.tex_v;
                end
            end
            ttf_pkg::OP_DET:
            begin
                if (!cmd.step[0])
                    acc_reg <= prod;
                else
                begin
                    det_neg_reg  <= acc_sub[ttf_pkg::ACCW-1];
                    det_zero_reg <= (acc_sub == '0);
                end
            end
            ttf_pkg::OP_TB:
            begin
                if (!cmd.step[0])
                    acc_reg <= prod;
                else
                begin
                    tb_reg[tb_d] <= tb_val;
                    if (tb_d == 3'd0 || tb_mag > m_tb_reg)
                        m_tb_reg <= tb_mag;
                end
            end
            ttf_pkg::OP_FIT_TB:
            begin
                if (m_tb_reg >= TB_LIM)
                begin
                    for (int k = 0; k < 6; k++)
                        tb_reg[k] <= tb_reg[k] >>> 1;
                    m_tb_reg <= m_tb_reg >> 1;
                end
            end
            ttf_pkg::OP_CROSS:
            begin
                if (!cmd.step[0])
                    acc_reg <= prod;
                else
                    c_reg[ax_j] <= ttf_pkg::CRW'(acc_sub);
            end
            ttf_pkg::OP_HAND:
            begin
                if (s2 == 2'd0)
                    acc_reg <= prod;
                else if (s2 == 2'd1)
                    acc_reg <= acc_add;
                else
                    hand_reg <= acc_add[ttf_pkg::ACCW-1];
            end
            ttf_pkg::OP_DOT:
            begin
                if (s2 == 2'd0)
                    acc_reg <= prod;
                else if (s2 == 2'd1)
                    acc_reg <= acc_add;
                else
                    dot_reg <= ttf_pkg::DOTW'(acc_add);
            end
            ttf_pkg::OP_VEC:
            begin
                v_reg[s2] <= vec_val;
                if (s2 == 2'd0 || vec_mag > m_v_reg)
                    m_v_reg <= vec_mag;
            end
            ttf_pkg::OP_FIT_V:
            begin
                if (m_v_reg >= V_LIM)
                begin
                    for (int k = 0; k < 3; k++)
                        v_reg[k] <= v_reg[k] >>> 1;
                    m_v_reg <= m_v_reg >> 1;
                end
            end
            ttf_pkg::OP_LEN2:
            begin
                if (s2 == 2'd0)
                    acc_reg <= prod;
                else if (s2 == 2'd1)
                    acc_reg <= acc_add;
                else
                begin
                    sq_x_reg   <= ttf_pkg::SQW'(acc_add);
                    sq_r_reg   <= '0;
                    sq_bit_reg <= SQ_TOP;
                end
            end
            ttf_pkg::OP_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_x_reg <= sq_x_reg - sq_sum;
                    sq_r_reg <= ttf_pkg::RW'((ttf_pkg::SQW'(sq_r_reg) >> 1) + sq_bit_reg);
                end
                else
                    sq_r_reg <= sq_r_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ttf_pkg::OP_DIV_INIT:
            begin
                rem_reg   <= ttf_pkg::REMW'(div_num >> ttf_pkg::QW);
                numlo_reg <= div_num[ttf_pkg::QW-1:0];
                q_reg     <= '0;
            end
            ttf_pkg::OP_DIV:
            begin
                rem_reg   <= div_ge ? rem_sh - ttf_pkg::REMW'(sq_r_reg) : rem_sh;
                numlo_reg <= numlo_reg << 1;
                q_reg     <= q_next;
                if (cmd.step == ttf_pkg::DIV_LAST)
                    tan_reg[cmd.comp] <= tan_val;
            end
            ttf_pkg::OP_EMIT:
            begin
                if (cmd.zero || sq_r_reg == '0)
                begin
                    result_reg.tangent_x <= '0;
                    result_reg.tangent_y <= '0;
                    result_reg.tangent_z <= '0;
                end
                else
                begin
                    result_reg.tangent_x <= tan_reg[0];
                    result_reg.tangent_y <= tan_reg[1];
                    result_reg.tangent_z <= tan_reg[2];
                end
                result_reg.handedness <= !cmd.zero && hand_reg;
                result_reg.degenerate <= cmd.zero || sq_r_reg == '0;
                result_reg.last       <= (cmd.corner == ttf_pkg::CORNER_LAST);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == ttf_pkg::OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.det_zero = det_zero_reg;
    assign status.tb_fit   = (m_tb_reg < TB_LIM);
    assign status.v_fit    = (m_v_reg < V_LIM);
    assign status.len_zero = (sq_r_reg == '0);
    assign status.out_free = out_free;
    assign result_valid    = out_valid_reg;
    assign result          = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ttf_pkg::OP_EMIT) |-> out_free)
        else $error("result overwritten while still waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ttf_pkg::OP_CROSS) |-> (m_tb_reg < TB_LIM))
        else $error("tangent and bitangent not scaled before use");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == ttf_pkg::OP_LEN2) |-> (m_v_reg < V_LIM))
        else $error("orthogonal tangent not scaled before length");

endmodule
